[rtl/core/bpro_pkg.sv]
// Shared types and constants for the bitplane raster-op ALU.
`default_nettype none

package bpro_pkg;

  localparam int unsigned OffsetW  = 14;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned PlaneCnt = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SlotW    = 4;
  localparam int unsigned MaxSlots = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegCommand     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegDrawColor   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPixelMask   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegBankDisable = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCmpSlots    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTilePattern = 3'd5;
  localparam logic [CfgIdxW-1:0] RegPageHidden  = 3'd6;

  // Command register bit positions
  localparam int unsigned CmdEnableBit = 7;
  localparam int unsigned CmdCmpWrBit  = 6;
  localparam int unsigned CmdNeqBit    = 5;

  // Register reset values
  localparam logic [ByteW-1:0]    BankDisableRst = 8'h08;
  localparam logic [CfgDataW-1:0] CmpSlotsRst    = 32'h8888_8888;

  typedef enum logic [2:0] {
    OP_PSET    = 3'd0,
    OP_PRESET  = 3'd1,
    OP_OR      = 3'd2,
    OP_AND     = 3'd3,
    OP_XOR     = 3'd4,
    OP_NOT     = 3'd5,
    OP_TILE    = 3'd6,
    OP_COMPARE = 3'd7
  } rop_op_e;

  typedef struct packed {
    logic    enable;
    logic    cmp_write;
    logic    write_neq;
    rop_op_e op;
  } rop_ctrl_t;

  typedef struct packed {
    logic [OffsetW-1:0] vram_offset;
    logic [ByteW-1:0]   blue_old;
    logic [ByteW-1:0]   red_old;
    logic [ByteW-1:0]   green_old;
  } in_item_t;

endpackage

`default_nettype wire

[rtl/core/bpro_if.sv]
// Item channel interfaces: memory access in, plane write out.
`default_nettype none

interface bpro_in_if;
  logic                          valid;
  logic                          ready;
  logic [bpro_pkg::OffsetW-1:0]  vram_offset;
  logic [bpro_pkg::ByteW-1:0]    blue_old;
  logic [bpro_pkg::ByteW-1:0]    red_old;
  logic [bpro_pkg::ByteW-1:0]    green_old;

  modport source (output valid, vram_offset, blue_old, red_old, green_old, input ready);
  modport sink   (input valid, vram_offset, blue_old, red_old, green_old, output ready);
endinterface

interface bpro_out_if;
  logic                          valid;
  logic                          ready;
  logic [bpro_pkg::OffsetW-1:0]  write_offset;
  logic [bpro_pkg::ByteW-1:0]    blue_new;
  logic [bpro_pkg::ByteW-1:0]    red_new;
  logic [bpro_pkg::ByteW-1:0]    green_new;
  logic [bpro_pkg::PlaneCnt-1:0] plane_write_enable;
  logic [bpro_pkg::ByteW-1:0]    match_status;

  modport source (output valid, write_offset, blue_new, red_new, green_new,
                  plane_write_enable, match_status, input ready);
  modport sink   (input valid, write_offset, blue_new, red_new, green_new,
                  plane_write_enable, match_status, output ready);
endinterface

`default_nettype wire

[rtl/core/bpro_color_cmp.sv]
// Eight-pixel color compare against the slot table.
`default_nettype none

module bpro_color_cmp #(
  parameter int unsigned SlotCount = 8
) (
  input  wire logic [bpro_pkg::ByteW-1:0]    blue_i,
  input  wire logic [bpro_pkg::ByteW-1:0]    red_i,
  input  wire logic [bpro_pkg::ByteW-1:0]    green_i,
  input  wire logic [bpro_pkg::CfgDataW-1:0] slots_i,
  input  wire logic [bpro_pkg::PlaneCnt-1:0] care_i,
  output logic      [bpro_pkg::ByteW-1:0]    match_o
);
  import bpro_pkg::*;

  always_comb begin
    logic [PlaneCnt-1:0] color;
    logic [SlotW-1:0]    slot;
    logic                hit;
    match_o = '0;
    for (int p = 0; p < ByteW; p++) begin
      color = {green_i[p], red_i[p], blue_i[p]};
      hit   = 1'b0;
      for (int j = 0; j < MaxSlots; j++) begin
        slot = slots_i[j*SlotW +: SlotW];
        // bit3 marks an unused slot
        if (j < SlotCount && !slot[SlotW-1] &&
            ((slot[PlaneCnt-1:0] & care_i) == (color & care_i))) begin
          hit = 1'b1;
        end
      end
      match_o[p] = hit;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bpro_plane_rop.sv]
// Raster operation, pixel mask merge and compare gate for one plane.
`default_nettype none

module bpro_plane_rop (
  input  wire bpro_pkg::rop_ctrl_t       ctrl_i,
  input  wire logic [bpro_pkg::ByteW-1:0] old_i,
  input  wire logic                       fill_i,
  input  wire logic [bpro_pkg::ByteW-1:0] tile_i,
  input  wire logic [bpro_pkg::ByteW-1:0] pixel_mask_i,
  input  wire logic [bpro_pkg::ByteW-1:0] gate_i,
  input  wire logic                       disabled_i,
  input  wire logic                       hidden_i,
  output logic      [bpro_pkg::ByteW-1:0] new_o,
  output logic                            we_o
);
  import bpro_pkg::*;

  logic [ByteW-1:0] fill;
  logic [ByteW-1:0] rop;
  logic [ByteW-1:0] merged;

  assign fill = {ByteW{fill_i}};

  always_comb begin
    unique case (ctrl_i.op)
      OP_PSET:    rop = fill;
      OP_PRESET:  rop = ~fill;
      OP_OR:      rop = fill | old_i;
      OP_AND:     rop = fill & old_i;
      OP_XOR:     rop = fill ^ old_i;
      OP_NOT:     rop = ~old_i;
      OP_TILE:    rop = tile_i;
      OP_COMPARE: rop = '0;
      default:    rop = '0;
    endcase
  end

  always_comb begin
    merged = (rop & ~pixel_mask_i) | (old_i & pixel_mask_i);
    merged = (old_i & ~gate_i) | (merged & gate_i);
  end

  assign we_o  = ctrl_i.enable && (ctrl_i.op != OP_COMPARE) && !disabled_i && !hidden_i;
  assign new_o = we_o ? merged : '0;

endmodule

`default_nettype wire

[rtl/core/bitplane_raster_op_alu.sv]
// Top level of the bitplane raster-op ALU with color compare.
//
// Usage:
//  - in_i carries one video memory access per item: the 14-bit offset and
//    the current blue, red and green bytes there. out_o returns one item per
//    access: the offset, the three bytes to write, a per-plane write enable
//    and the latest eight-pixel compare status.
//  - Registers (command, draw color, pixel mask, bank disable, compare slots,
//    tile pattern, page hidden) are written through cfg_we_i / cfg_index_i /
//    cfg_data_i, one per cycle. The user must write them only while no item
//    is in flight; the block itself does not enforce this.
//  - An item passes the input register, then the result register, before
//    out_o.valid rises. Throughput: one item per cycle unless out_o stalls;
//    in between lie only the compare tree and the per-plane byte logic.
//  - When the receiver stalls, the result register holds its item and the
//    input register can still take one more; in_i.ready drops only when
//    both are full.
//  - Reset: both stages empty, registers at their documented reset values,
//    compare status cleared.
`default_nettype none

module bitplane_raster_op_alu #(
  parameter int unsigned COMPARE_SLOT_COUNT = 8
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  bpro_in_if.sink                              in_i,
  bpro_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [bpro_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [bpro_pkg::CfgDataW-1:0]   cfg_data_i
);
  import bpro_pkg::*;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [ByteW-1:0]      command_q;
  logic [ByteW-1:0]      draw_color_q;
  logic [ByteW-1:0]      pixel_mask_q;
  logic [ByteW-1:0]      bank_disable_q;
  logic [CfgDataW-1:0]   cmp_slots_q;
  logic [3*ByteW-1:0]    tile_pattern_q;
  logic [PlaneCnt-1:0]   page_hidden_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      command_q      <= '0;
      draw_color_q   <= '0;
      pixel_mask_q   <= '0;
      bank_disable_q <= BankDisableRst;
      cmp_slots_q    <= CmpSlotsRst;
      tile_pattern_q <= '0;
      page_hidden_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegCommand:     command_q      <= cfg_data_i[ByteW-1:0];
        RegDrawColor:   draw_color_q   <= cfg_data_i[ByteW-1:0];
        RegPixelMask:   pixel_mask_q   <= cfg_data_i[ByteW-1:0];
        RegBankDisable: bank_disable_q <= cfg_data_i[ByteW-1:0];
        RegCmpSlots:    cmp_slots_q    <= cfg_data_i;
        RegTilePattern: tile_pattern_q <= cfg_data_i[3*ByteW-1:0];
        RegPageHidden:  page_hidden_q  <= cfg_data_i[PlaneCnt-1:0];
        default: ;  // unknown index: write dropped
      endcase
    end
  end

  rop_ctrl_t ctrl;
  assign ctrl.enable    = command_q[CmdEnableBit];
  assign ctrl.cmp_write = command_q[CmdCmpWrBit];
  assign ctrl.write_neq = command_q[CmdNeqBit];
  assign ctrl.op        = rop_op_e'(command_q[2:0]);

  // ---------------------------------------------------------------------
  // Handshake: input stage feeds result stage
  // ---------------------------------------------------------------------
  logic     s1_valid_q;
  in_item_t s1_item_q;
  logic     out_valid_q;
  logic     out_load;
  logic     s1_load;

  assign out_load    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign s1_load     = in_i.valid && in_i.ready;
  assign in_i.ready  = !s1_valid_q || out_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_item_q.vram_offset <= in_i.vram_offset;
      s1_item_q.blue_old    <= in_i.blue_old;
      s1_item_q.red_old     <= in_i.red_old;
      s1_item_q.green_old   <= in_i.green_old;
    end
  end

  // ---------------------------------------------------------------------
  // Datapath for the item in the input stage
  // ---------------------------------------------------------------------
  logic [ByteW-1:0] rd [PlaneCnt];

  // hidden pages read as all ones
  assign rd[0] = page_hidden_q[0] ? '1 : s1_item_q.blue_old;
  assign rd[1] = page_hidden_q[1] ? '1 : s1_item_q.red_old;
  assign rd[2] = page_hidden_q[2] ? '1 : s1_item_q.green_old;

  logic [ByteW-1:0] match;
  logic [ByteW-1:0] cmp_result_q;
  logic [ByteW-1:0] cmp_result_d;
  logic             cmp_run;

  bpro_color_cmp #(
    .SlotCount (COMPARE_SLOT_COUNT)
  ) u_cmp (
    .blue_i  (rd[0]),
    .red_i   (rd[1]),
    .green_i (rd[2]),
    .slots_i (cmp_slots_q),
    .care_i  (~bank_disable_q[PlaneCnt-1:0]),
    .match_o (match)
  );

  // compare runs in compare-write mode and for the compare-only operation
  assign cmp_run      = ctrl.enable && (ctrl.cmp_write || (ctrl.op == OP_COMPARE));
  assign cmp_result_d = cmp_run ? match : cmp_result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmp_result_q <= '0;
    end else if (out_load) begin
      cmp_result_q <= cmp_result_d;
    end
  end

  // write gate: open everywhere unless compare-write mode
  logic [ByteW-1:0] gate;
  always_comb begin
    if (ctrl.cmp_write) begin
      gate = ctrl.write_neq ? ~cmp_result_d : cmp_result_d;
    end else begin
      gate = '1;
    end
  end

  logic [ByteW-1:0]    new_byte [PlaneCnt];
  logic [PlaneCnt-1:0] plane_we;

  for (genvar g = 0; g < PlaneCnt; g++) begin : g_plane
    bpro_plane_rop u_rop (
      .ctrl_i       (ctrl),
      .old_i        (rd[g]),
      .fill_i       (draw_color_q[g]),
      .tile_i       (tile_pattern_q[g*ByteW +: ByteW]),
      .pixel_mask_i (pixel_mask_q),
      .gate_i       (gate),
      .disabled_i   (bank_disable_q[g]),
      .hidden_i     (page_hidden_q[g]),
      .new_o        (new_byte[g]),
      .we_o         (plane_we[g])
    );
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  logic [OffsetW-1:0]  write_offset_q;
  logic [ByteW-1:0]    blue_new_q;
  logic [ByteW-1:0]    red_new_q;
  logic [ByteW-1:0]    green_new_q;
  logic [PlaneCnt-1:0] plane_we_q;
  logic [ByteW-1:0]    match_status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      write_offset_q <= s1_item_q.vram_offset;
      blue_new_q     <= new_byte[0];
      red_new_q      <= new_byte[1];
      green_new_q    <= new_byte[2];
      plane_we_q     <= plane_we;
      match_status_q <= cmp_result_d;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.write_offset       = write_offset_q;
  assign out_o.blue_new           = blue_new_q;
  assign out_o.red_new            = red_new_q;
  assign out_o.green_new          = green_new_q;
  assign out_o.plane_write_enable = plane_we_q;
  assign out_o.match_status       = match_status_q;

endmodule

`default_nettype wire
